// File: rtl/bqf_pkg.sv
// ----------------------------------------------------------------------------
// bqf_pkg
// Shared widths, register map, command encodings and types of the biquad core.
// ----------------------------------------------------------------------------
package bqf_pkg;

  // Sample and coefficient formats
  localparam int SAMPLE_W  = 24;
  localparam int COEF_W    = 32;
  localparam int COEF_FRAC = COEF_W - 3;          // Q3.29
  localparam int PROD_W    = SAMPLE_W + COEF_W;   // one product, also TDF2 state width
  localparam int STATE_W   = PROD_W;
  localparam int SUM_W     = PROD_W + 3;          // room for five products
  localparam int RND_W     = SUM_W + 1 - COEF_FRAC;

  localparam logic signed [COEF_W-1:0] COEF_ONE =
    {3'b001, {COEF_FRAC{1'b0}}};

  // Configuration port
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  localparam logic [2:0] REG_B0   = 3'd0;
  localparam logic [2:0] REG_B1   = 3'd1;
  localparam logic [2:0] REG_B2   = 3'd2;
  localparam logic [2:0] REG_A1   = 3'd3;
  localparam logic [2:0] REG_A2   = 3'd4;
  localparam logic [2:0] REG_FORM = 3'd5;

  // Sequencer step limits
  localparam int          STEP_W        = 3;
  localparam logic [2:0]  DF1_LAST_STEP = 3'd4;
  localparam logic [2:0]  B_LAST_STEP   = 3'd3;

  typedef enum logic [2:0] {
    COEF_B0,
    COEF_B1,
    COEF_B2,
    COEF_A1,
    COEF_A2
  } coef_sel_e;

  typedef enum logic [2:0] {
    OPND_X,
    OPND_H1,
    OPND_H2,
    OPND_O1,
    OPND_O2,
    OPND_Y
  } opnd_sel_e;

  typedef enum logic [1:0] {
    DST_MAIN,
    DST_S1,
    DST_S2
  } acc_dst_e;

  typedef struct packed {
    logic signed [COEF_W-1:0] b0;
    logic signed [COEF_W-1:0] b1;
    logic signed [COEF_W-1:0] b2;
    logic signed [COEF_W-1:0] a1;
    logic signed [COEF_W-1:0] a2;
  } bqf_coef_t;

  // Controller to datapath command
  typedef struct packed {
    logic      start;   // capture the input sample, init accumulators
    logic      tdf2;    // transposed direct form 2 selected
    logic      mul_en;  // issue one multiply
    coef_sel_e coef;
    opnd_sel_e opnd;
    acc_dst_e  dst;
    logic      neg;     // subtract the product
    logic      round;   // round and saturate main accumulator into y
    logic      commit;  // load output register, update filter state
  } bqf_cmd_t;

endpackage

// File: rtl/bqf_regs.sv
// ----------------------------------------------------------------------------
// bqf_regs
// APB-style configuration registers: five coefficients and the form select.
// ----------------------------------------------------------------------------
module bqf_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bqf_pkg::ADDR_W-1:0]  paddr,
  input  logic [bqf_pkg::DATA_W-1:0]  pwdata,
  output logic [bqf_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output bqf_pkg::bqf_coef_t          coef_o,
  output logic                        form_o
);

  bqf_pkg::bqf_coef_t coef_q;
  logic               form_q;
  logic [2:0]         reg_idx;
  logic               wr_en;

  assign reg_idx = paddr[4:2];
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q.b0 <= bqf_pkg::COEF_ONE;
      coef_q.b1 <= '0;
      coef_q.b2 <= '0;
      coef_q.a1 <= '0;
      coef_q.a2 <= '0;
      form_q    <= 1'b0;
    end else if (wr_en) begin
      case (reg_idx)
        bqf_pkg::REG_B0:   coef_q.b0 <= pwdata;
        bqf_pkg::REG_B1:   coef_q.b1 <= pwdata;
        bqf_pkg::REG_B2:   coef_q.b2 <= pwdata;
        bqf_pkg::REG_A1:   coef_q.a1 <= pwdata;
        bqf_pkg::REG_A2:   coef_q.a2 <= pwdata;
        bqf_pkg::REG_FORM: form_q    <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      bqf_pkg::REG_B0:   prdata = coef_q.b0;
      bqf_pkg::REG_B1:   prdata = coef_q.b1;
      bqf_pkg::REG_B2:   prdata = coef_q.b2;
      bqf_pkg::REG_A1:   prdata = coef_q.a1;
      bqf_pkg::REG_A2:   prdata = coef_q.a2;
      bqf_pkg::REG_FORM: prdata = {{(bqf_pkg::DATA_W-1){1'b0}}, form_q};
      default:           prdata = '0;
    endcase
  end

  assign coef_o = coef_q;
  assign form_o = form_q;

endmodule

// File: rtl/bqf_datapath.sv
// ----------------------------------------------------------------------------
// bqf_datapath
// Shared multiplier, three accumulators, rounding/saturation and filter state.
// ----------------------------------------------------------------------------
module bqf_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  bqf_pkg::bqf_cmd_t                   cmd_i,
  input  bqf_pkg::bqf_coef_t                  coef_i,
  input  logic signed [bqf_pkg::SAMPLE_W-1:0] sample_in_i,
  input  logic                                clear_history_i,
  output logic signed [bqf_pkg::SAMPLE_W-1:0] sample_out_o,
  output logic                                saturated_o
);

  localparam int SW = bqf_pkg::SAMPLE_W;
  localparam int CW = bqf_pkg::COEF_W;
  localparam int PW = bqf_pkg::PROD_W;
  localparam int TW = bqf_pkg::STATE_W;
  localparam int AW = bqf_pkg::SUM_W;
  localparam int RW = bqf_pkg::RND_W;
  localparam int CF = bqf_pkg::COEF_FRAC;

  localparam logic [AW:0] RND_HALF = {{(AW-CF+1){1'b0}}, 1'b1, {(CF-1){1'b0}}};

  // Filter state
  logic signed [SW-1:0] x_q;
  logic signed [SW-1:0] h1_q, h2_q, o1_q, o2_q;
  logic signed [TW-1:0] st1_q, st2_q;

  // Accumulation
  logic signed [AW-1:0] main_q, s1_q, s2_q;
  logic signed [PW-1:0] prod_q;
  logic                 prod_vld_q;
  bqf_pkg::acc_dst_e    prod_dst_q;
  logic                 prod_neg_q;

  logic signed [SW-1:0] y_q;
  logic                 ysat_q;
  logic signed [SW-1:0] out_q;
  logic                 out_sat_q;

  logic signed [CW-1:0] coef_mux;
  logic signed [SW-1:0] opnd_mux;
  logic signed [PW-1:0] prod_d;
  logic signed [AW-1:0] prod_ext;
  logic signed [AW-1:0] addend;

  logic [AW:0]          rnd_sum;
  logic [RW-1:0]        rnd_shift;
  logic                 rnd_ovf;
  logic signed [SW-1:0] y_d;

  logic                 s1_ovf, s2_ovf;
  logic signed [TW-1:0] s1_clamp, s2_clamp;

  // Operand selection for the shared multiplier
  always_comb begin
    case (cmd_i.coef)
      bqf_pkg::COEF_B0: coef_mux = coef_i.b0;
      bqf_pkg::COEF_B1: coef_mux = coef_i.b1;
      bqf_pkg::COEF_B2: coef_mux = coef_i.b2;
      bqf_pkg::COEF_A1: coef_mux = coef_i.a1;
      bqf_pkg::COEF_A2: coef_mux = coef_i.a2;
      default:          coef_mux = '0;
    endcase
    case (cmd_i.opnd)
      bqf_pkg::OPND_X:  opnd_mux = x_q;
      bqf_pkg::OPND_H1: opnd_mux = h1_q;
      bqf_pkg::OPND_H2: opnd_mux = h2_q;
      bqf_pkg::OPND_O1: opnd_mux = o1_q;
      bqf_pkg::OPND_O2: opnd_mux = o2_q;
      bqf_pkg::OPND_Y:  opnd_mux = y_q;
      default:          opnd_mux = '0;
    endcase
  end

  assign prod_d   = coef_mux * opnd_mux;
  assign prod_ext = {{(AW-PW){prod_q[PW-1]}}, prod_q};
  assign addend   = prod_neg_q ? -prod_ext : prod_ext;

  // Round half up by the fraction bits, then clip to the sample range
  assign rnd_sum   = {main_q[AW-1], main_q} + RND_HALF;
  assign rnd_shift = rnd_sum[AW:CF];
  assign rnd_ovf   = !((&rnd_shift[RW-1:SW-1]) || !(|rnd_shift[RW-1:SW-1]));
  assign y_d       = rnd_ovf ? (rnd_shift[RW-1] ? {1'b1, {(SW-1){1'b0}}}
                                                : {1'b0, {(SW-1){1'b1}}})
                             : rnd_shift[SW-1:0];

  // Clip transposed accumulators to the state width
  assign s1_ovf   = !((&s1_q[AW-1:TW-1]) || !(|s1_q[AW-1:TW-1]));
  assign s2_ovf   = !((&s2_q[AW-1:TW-1]) || !(|s2_q[AW-1:TW-1]));
  assign s1_clamp = s1_ovf ? (s1_q[AW-1] ? {1'b1, {(TW-1){1'b0}}}
                                         : {1'b0, {(TW-1){1'b1}}})
                           : s1_q[TW-1:0];
  assign s2_clamp = s2_ovf ? (s2_q[AW-1] ? {1'b1, {(TW-1){1'b0}}}
                                         : {1'b0, {(TW-1){1'b1}}})
                           : s2_q[TW-1:0];

  // Filter state and product valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h1_q       <= '0;
      h2_q       <= '0;
      o1_q       <= '0;
      o2_q       <= '0;
      st1_q      <= '0;
      st2_q      <= '0;
      prod_vld_q <= 1'b0;
    end else begin
      prod_vld_q <= cmd_i.mul_en;
      if (cmd_i.start && clear_history_i) begin
        h1_q  <= '0;
        h2_q  <= '0;
        o1_q  <= '0;
        o2_q  <= '0;
        st1_q <= '0;
        st2_q <= '0;
      end else if (cmd_i.commit) begin
        if (cmd_i.tdf2) begin
          st1_q <= s1_clamp;
          st2_q <= s2_clamp;
        end else begin
          h2_q <= h1_q;
          h1_q <= x_q;
          o2_q <= o1_q;
          o1_q <= y_q;
        end
      end
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q     <= prod_d;
      prod_dst_q <= cmd_i.dst;
      prod_neg_q <= cmd_i.neg;
    end
    if (cmd_i.start) begin
      x_q    <= sample_in_i;
      // TDF2 starts from the stored accumulators, DF1 from zero
      main_q <= (cmd_i.tdf2 && !clear_history_i) ? {{(AW-TW){st1_q[TW-1]}}, st1_q} : '0;
      s1_q   <= clear_history_i ? '0 : {{(AW-TW){st2_q[TW-1]}}, st2_q};
      s2_q   <= '0;
    end else if (prod_vld_q) begin
      case (prod_dst_q)
        bqf_pkg::DST_MAIN: main_q <= main_q + addend;
        bqf_pkg::DST_S1:   s1_q   <= s1_q + addend;
        bqf_pkg::DST_S2:   s2_q   <= s2_q + addend;
        default: ;
      endcase
    end
    if (cmd_i.round) begin
      y_q    <= y_d;
      ysat_q <= rnd_ovf;
    end
    if (cmd_i.commit) begin
      out_q     <= y_q;
      out_sat_q <= ysat_q;
    end
  end

  assign sample_out_o = out_q;
  assign saturated_o  = out_sat_q;

endmodule

// File: rtl/bqf_ctrl.sv
// ----------------------------------------------------------------------------
// bqf_ctrl
// Sequencer: steps the shared multiplier through the taps of the selected
// form and owns the input and output handshakes.
// ----------------------------------------------------------------------------
module bqf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              form_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output bqf_pkg::bqf_cmd_t cmd_o
);

  typedef enum logic [6:0] {
    ST_IDLE    = 7'b0000001,
    ST_MUL_A   = 7'b0000010,
    ST_DRAIN_A = 7'b0000100,
    ST_ROUND   = 7'b0001000,
    ST_MUL_B   = 7'b0010000,
    ST_DRAIN_B = 7'b0100000,
    ST_DONE    = 7'b1000000
  } state_e;

  state_e                      state_q, state_d;
  logic [bqf_pkg::STEP_W-1:0]  step_q, step_d;
  logic                        out_vld_q, out_vld_d;
  logic                        out_free;

  assign out_free   = !out_vld_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d      = state_q;
    step_d       = step_q;
    cmd_o        = '0;
    cmd_o.tdf2   = form_i;
    cmd_o.coef   = bqf_pkg::COEF_B0;
    cmd_o.opnd   = bqf_pkg::OPND_X;
    cmd_o.dst    = bqf_pkg::DST_MAIN;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          step_d      = '0;
          state_d     = ST_MUL_A;
        end
      end
      ST_MUL_A: begin
        cmd_o.mul_en = 1'b1;
        if (form_i) begin
          state_d = ST_DRAIN_A;
        end else begin
          case (step_q)
            3'd0: begin cmd_o.coef = bqf_pkg::COEF_B0; cmd_o.opnd = bqf_pkg::OPND_X;  end
            3'd1: begin cmd_o.coef = bqf_pkg::COEF_B1; cmd_o.opnd = bqf_pkg::OPND_H1; end
            3'd2: begin cmd_o.coef = bqf_pkg::COEF_B2; cmd_o.opnd = bqf_pkg::OPND_H2; end
            3'd3: begin
              cmd_o.coef = bqf_pkg::COEF_A1;
              cmd_o.opnd = bqf_pkg::OPND_O1;
              cmd_o.neg  = 1'b1;
            end
            default: begin
              cmd_o.coef = bqf_pkg::COEF_A2;
              cmd_o.opnd = bqf_pkg::OPND_O2;
              cmd_o.neg  = 1'b1;
            end
          endcase
          if (step_q == bqf_pkg::DF1_LAST_STEP) begin
            state_d = ST_DRAIN_A;
          end else begin
            step_d = step_q + 1'b1;
          end
        end
      end
      ST_DRAIN_A: begin
        state_d = ST_ROUND;
      end
      ST_ROUND: begin
        cmd_o.round = 1'b1;
        step_d      = '0;
        state_d     = form_i ? ST_MUL_B : ST_DONE;
      end
      ST_MUL_B: begin
        // feedforward and feedback terms of the two transposed stages
        cmd_o.mul_en = 1'b1;
        case (step_q)
          3'd0: begin
            cmd_o.coef = bqf_pkg::COEF_B1;
            cmd_o.opnd = bqf_pkg::OPND_X;
            cmd_o.dst  = bqf_pkg::DST_S1;
          end
          3'd1: begin
            cmd_o.coef = bqf_pkg::COEF_A1;
            cmd_o.opnd = bqf_pkg::OPND_Y;
            cmd_o.dst  = bqf_pkg::DST_S1;
            cmd_o.neg  = 1'b1;
          end
          3'd2: begin
            cmd_o.coef = bqf_pkg::COEF_B2;
            cmd_o.opnd = bqf_pkg::OPND_X;
            cmd_o.dst  = bqf_pkg::DST_S2;
          end
          default: begin
            cmd_o.coef = bqf_pkg::COEF_A2;
            cmd_o.opnd = bqf_pkg::OPND_Y;
            cmd_o.dst  = bqf_pkg::DST_S2;
            cmd_o.neg  = 1'b1;
          end
        endcase
        if (step_q == bqf_pkg::B_LAST_STEP) begin
          state_d = ST_DRAIN_B;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      ST_DRAIN_B: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        // hold until the output register can take the result
        if (out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (cmd_o.commit) begin
      out_vld_d = 1'b1;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      step_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      step_q    <= step_d;
      out_vld_q <= out_vld_d;
    end
  end

  assign out_valid_o = out_vld_q;

  // A new result appears only out of the commit state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(state_q == ST_DONE))
    else $error("output valid rose outside commit");

  // An accepted transaction always starts the multiply sequence
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == ST_MUL_A) && (step_q == '0))
    else $error("accepted transaction did not start sequence");

  // A full, stalled output register blocks the commit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && out_vld_q && out_stall_i) |=> (state_q == ST_DONE) && out_vld_q)
    else $error("result committed over a pending output");

  // The transposed stage sequence never runs past its last tap
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL_B) |-> (step_q <= bqf_pkg::B_LAST_STEP))
    else $error("step counter out of range");

endmodule

// File: rtl/biquad_iir_filter_core.sv
// ----------------------------------------------------------------------------
// biquad_iir_filter_core
// Fixed-point biquad filter, direct form 1 or transposed direct form 2.
// ----------------------------------------------------------------------------
// Timing: set by the single shared 32x24 multiplier, used once per coefficient,
//   plus drain and round, and by a stalled output, which holds the commit.
// Throughput: a new sample is taken only in idle, after the last result is
//   committed to the output register.
// Reset: coefficients to a unity pass (b0 = 1.0), direct form 1, all history
//   cleared, accumulators not reset; no clearing pass, ready right after reset.
module biquad_iir_filter_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input samples
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [bqf_pkg::SAMPLE_W-1:0] sample_in_i,
  input  logic                                clear_history_i,
  // output samples
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [bqf_pkg::SAMPLE_W-1:0] sample_out_o,
  output logic                                saturated_o,
  // configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [bqf_pkg::ADDR_W-1:0]          paddr,
  input  logic [bqf_pkg::DATA_W-1:0]          pwdata,
  output logic [bqf_pkg::DATA_W-1:0]          prdata,
  output logic                                pready
);

  bqf_pkg::bqf_coef_t coef;
  logic               form;
  bqf_pkg::bqf_cmd_t  cmd;

  bqf_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .coef_o  (coef),
    .form_o  (form)
  );

  bqf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .form_i      (form),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  bqf_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .coef_i          (coef),
    .sample_in_i     (sample_in_i),
    .clear_history_i (clear_history_i),
    .sample_out_o    (sample_out_o),
    .saturated_o     (saturated_o)
  );

endmodule
